@@ hdl/orfb_pkg.sv @@
// ----------------------------------------------------------------------------
// orfb_pkg
// shared widths, command codes and helper functions of the frame ring buffer
// ----------------------------------------------------------------------------
package orfb_pkg;

   localparam int DEPTH     = 32;
   localparam int PTR_W     = $clog2(DEPTH);
   localparam int CAP_W     = 6;
   localparam int CAP_MAX   = (DEPTH > 63) ? 63 : DEPTH;
   localparam int CAP_RESET = 32;
   localparam int CMP_W     = (PTR_W + 1 > CAP_W) ? PTR_W + 1 : CAP_W;

   localparam int ID_W   = 29;
   localparam int FLG_W  = 2;
   localparam int LEN_W  = 4;
   localparam int DAT_W  = 64;
   localparam int TIM_W  = 32;
   localparam int CNT_W  = 32;
   localparam int CMD_W  = 2;
   localparam int SLOT_W = ID_W + FLG_W + LEN_W + DAT_W + TIM_W;
   localparam int REQ_W  = ((SLOT_W + 7) / 8) * 8;
   localparam int RSP_W  = SLOT_W + 2 * CAP_W + 1 + 3 * CNT_W;
   localparam int CSR_W  = 8;

   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [CAP_W-1:0] cap_type;
   typedef logic [CNT_W-1:0] cnt_type;

   function automatic cap_type limit_cap(input cap_type v);
      cap_type r;
      if (v == '0) begin
         r = cap_type'(1);
      end else if (v > cap_type'(CAP_MAX)) begin
         r = cap_type'(CAP_MAX);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic ptr_type advance(input ptr_type p, input cap_type c);
      logic [CMP_W-1:0] n;
      ptr_type          r;
      n = CMP_W'(p) + CMP_W'(1);
      if (n >= CMP_W'(c)) begin
         r = '0;
      end else begin
         r = n[PTR_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ hdl/overwriting_frame_ring_buffer.sv @@
// ----------------------------------------------------------------------------
// overwriting_frame_ring_buffer
// ring buffer of can frames with insertion time; a put into a full buffer
// overwrites the oldest frame; status and statistics come with every result
// ----------------------------------------------------------------------------
// results: put, clear and empty get/peek give the result in the cycle after accept;
//   a get or peek that returns a frame first passes the read state (one slot ram read)
// flow: one item at a time; no new request while a read or an untaken result waits
// reset: pointers, fill level, high-water mark and counters clear at once,
//   capacity returns to 32; slot contents are not cleared
module overwriting_frame_ring_buffer
   import orfb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_wdata,   // capacity[5:0], zero pad
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [CMD_W-1:0] req_tuser,   // command
   // frame_id, frame_flags, frame_length, frame_data, now_micros, zero pad
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic             rsp_tuser,   // item_valid
   // out_frame_id, out_frame_flags, out_frame_length, out_frame_data,
   // out_insertion_time, occupancy, is_full, high_water, put_count, get_count,
   // overflow_count
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic    state_ff, state_in;
   cap_type cap_ff, cap_in;
   ptr_type wr_ptr_ff, wr_ptr_in;
   ptr_type rd_ptr_ff, rd_ptr_in;
   logic    full_ff, full_in;
   cap_type fill_ff, fill_in;
   cap_type peak_ff, peak_in;
   cnt_type put_cnt_ff, put_cnt_in;
   cnt_type get_cnt_ff, get_cnt_in;
   cnt_type ovf_cnt_ff, ovf_cnt_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    item_valid_ff, item_valid_in;

   logic              req_accept;
   logic              csr_accept;
   logic              fetch;
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [SLOT_W-1:0] ram_rd_data;
   cap_type           fill_next;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign fetch      = ((req_tuser == CMD_GET) || (req_tuser == CMD_PEEK)) &&
                       (fill_ff != '0);
   assign ram_wr_en  = req_accept && (req_tuser == CMD_PUT);
   assign ram_rd_en  = req_accept && fetch;
   assign fill_next  = full_ff ? fill_ff : fill_ff + cap_type'(1);

   orfb_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_tdata[SLOT_W-1:0]),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      full_in       = full_ff;
      fill_in       = fill_ff;
      peak_in       = peak_ff;
      put_cnt_in    = put_cnt_ff;
      get_cnt_in    = get_cnt_ff;
      ovf_cnt_in    = ovf_cnt_ff;
      item_valid_in = item_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      if (state_ff == ST_READ) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
      end

      if (csr_accept) begin
         cap_in    = limit_cap(csr_wdata[CAP_W-1:0]);
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         full_in   = 1'b0;
         fill_in   = '0;
      end

      if (req_accept) begin
         item_valid_in = fetch;
         if (fetch) begin
            state_in = ST_READ;
         end else begin
            rsp_valid_in = 1'b1;
         end
         case (req_tuser)
            CMD_PUT: begin
               if (full_ff) begin
                  rd_ptr_in  = advance(rd_ptr_ff, cap_ff);
                  ovf_cnt_in = ovf_cnt_ff + cnt_type'(1);
               end
               wr_ptr_in  = advance(wr_ptr_ff, cap_ff);
               fill_in    = fill_next;
               full_in    = (fill_next == cap_ff);
               put_cnt_in = put_cnt_ff + cnt_type'(1);
               if (fill_next > peak_ff) begin
                  peak_in = fill_next;
               end
            end
            CMD_GET: begin
               if (fetch) begin
                  full_in    = 1'b0;
                  rd_ptr_in  = advance(rd_ptr_ff, cap_ff);
                  fill_in    = fill_ff - cap_type'(1);
                  get_cnt_in = get_cnt_ff + cnt_type'(1);
               end
            end
            CMD_PEEK: begin
            end
            CMD_CLEAR: begin
               wr_ptr_in = '0;
               rd_ptr_in = '0;
               full_in   = 1'b0;
               fill_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cap_ff        <= limit_cap(cap_type'(CAP_RESET));
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         full_ff       <= 1'b0;
         fill_ff       <= '0;
         peak_ff       <= '0;
         put_cnt_ff    <= '0;
         get_cnt_ff    <= '0;
         ovf_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         item_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         full_ff       <= full_in;
         fill_ff       <= fill_in;
         peak_ff       <= peak_in;
         put_cnt_ff    <= put_cnt_in;
         get_cnt_ff    <= get_cnt_in;
         ovf_cnt_ff    <= ovf_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         item_valid_ff <= item_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = item_valid_ff;
   assign rsp_tdata  = {ovf_cnt_ff, get_cnt_ff, put_cnt_ff, peak_ff, full_ff, fill_ff,
                        {SLOT_W{item_valid_ff}} & ram_rd_data};

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cap_ff)
      else $error("fill level above capacity");

   a_full_matches_fill: assert property (@(posedge clock) disable iff (reset)
      full_ff == (fill_ff == cap_ff))
      else $error("full flag disagrees with fill level");

   a_peak_covers_fill: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= fill_ff)
      else $error("high-water mark below fill level");

   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_IDLE) && rsp_valid_ff && item_valid_ff)
      else $error("slot read did not complete in one cycle");

   a_fetch_needs_frame: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> (fill_ff != '0) && !ram_wr_en)
      else $error("slot read issued on empty buffer");

endmodule

@@ hdl/orfb_ram.sv @@
// ----------------------------------------------------------------------------
// orfb_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module orfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the overwriting frame ring buffer: directed and
// random put, get, peek and clear commands under several capacities, with
// random stalls on both streams; a scoreboard predicts every status item
// ----------------------------------------------------------------------------
module tb
   import orfb_pkg::*;
;

   localparam int RUN_LIMIT   = 400000;
   localparam int PHASE_ITEMS = 150;

   typedef struct packed {
      logic [REQ_W-SLOT_W-1:0] pad;
      logic [TIM_W-1:0]        now_micros;
      logic [DAT_W-1:0]        frame_data;
      logic [LEN_W-1:0]        frame_length;
      logic [FLG_W-1:0]        frame_flags;
      logic [ID_W-1:0]         frame_id;
   } frame_request_type;

   typedef struct packed {
      cnt_type          overflow_count;
      cnt_type          get_count;
      cnt_type          put_count;
      cap_type          high_water;
      logic             is_full;
      cap_type          occupancy;
      logic [TIM_W-1:0] insertion_time;
      logic [DAT_W-1:0] frame_data;
      logic [LEN_W-1:0] frame_length;
      logic [FLG_W-1:0] frame_flags;
      logic [ID_W-1:0]  frame_id;
   } frame_status_type;

   typedef struct {
      logic             item;
      frame_status_type status;
   } frame_result_type;

   class frame_ring_scoreboard;
      logic [ID_W-1:0]  slot_id     [DEPTH];
      logic [FLG_W-1:0] slot_flags  [DEPTH];
      logic [LEN_W-1:0] slot_length [DEPTH];
      logic [DAT_W-1:0] slot_data   [DEPTH];
      logic [TIM_W-1:0] slot_time   [DEPTH];
      int unsigned      wr_ptr;
      int unsigned      rd_ptr;
      int unsigned      fill;
      int unsigned      peak;
      int unsigned      cap;
      bit               full;
      cnt_type          puts;
      cnt_type          gets;
      cnt_type          overflows;
      frame_result_type expected_status[$];
      int unsigned      errors;

      function new();
         cap       = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;
         peak      = 0;
         puts      = '0;
         gets      = '0;
         overflows = '0;
         errors    = 0;
         empty_ring();
      endfunction

      function void empty_ring();
         wr_ptr = 0;
         rd_ptr = 0;
         full   = 1'b0;
         fill   = 0;
      endfunction

      function int unsigned next_slot(int unsigned p);
         return (p + 1 >= cap) ? 0 : p + 1;
      endfunction

      function void apply_capacity(logic [CSR_W-1:0] wdata);
         int unsigned v;
         v = wdata[CAP_W-1:0];
         if (v == 0) begin
            cap = 1;
         end else if (v > DEPTH) begin
            cap = DEPTH;
         end else begin
            cap = v;
         end
         empty_ring();
      endfunction

      function void note_command(logic [CMD_W-1:0] cmd, frame_request_type req);
         frame_result_type res;
         res.item   = 1'b0;
         res.status = '0;
         if (wr_ptr >= cap) wr_ptr = 0;
         if (rd_ptr >= cap) rd_ptr = 0;
         case (cmd)
            CMD_PUT: begin
               slot_id[wr_ptr]     = req.frame_id;
               slot_flags[wr_ptr]  = req.frame_flags;
               slot_length[wr_ptr] = req.frame_length;
               slot_data[wr_ptr]   = req.frame_data;
               slot_time[wr_ptr]   = req.now_micros;
               if (full) begin
                  rd_ptr    = next_slot(rd_ptr);
                  overflows = overflows + 1;
               end
               wr_ptr = next_slot(wr_ptr);
               full   = (wr_ptr == rd_ptr);
               if (full) begin
                  fill = cap;
               end else if (wr_ptr >= rd_ptr) begin
                  fill = wr_ptr - rd_ptr;
               end else begin
                  fill = cap + wr_ptr - rd_ptr;
               end
               if (fill > peak) peak = fill;
               puts = puts + 1;
            end
            CMD_GET, CMD_PEEK: begin
               if (fill > 0) begin
                  res.item                  = 1'b1;
                  res.status.frame_id       = slot_id[rd_ptr];
                  res.status.frame_flags    = slot_flags[rd_ptr];
                  res.status.frame_length   = slot_length[rd_ptr];
                  res.status.frame_data     = slot_data[rd_ptr];
                  res.status.insertion_time = slot_time[rd_ptr];
                  if (cmd == CMD_GET) begin
                     full   = 1'b0;
                     rd_ptr = next_slot(rd_ptr);
                     fill   = fill - 1;
                     gets   = gets + 1;
                  end
               end
            end
            default: begin
               empty_ring();
            end
         endcase
         res.status.occupancy      = cap_type'(fill);
         res.status.is_full        = full;
         res.status.high_water     = cap_type'(peak);
         res.status.put_count      = puts;
         res.status.get_count      = gets;
         res.status.overflow_count = overflows;
         expected_status.push_back(res);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_status(logic item, frame_status_type got);
         frame_result_type res;
         if (expected_status.size() == 0) begin
            $error("unexpected status item 0x%0h", got);
            errors++;
            return;
         end
         res = expected_status.pop_front();
         compare_field("item_valid", 64'(res.item), 64'(item));
         compare_field("out_frame_id", 64'(res.status.frame_id), 64'(got.frame_id));
         compare_field("out_frame_flags", 64'(res.status.frame_flags),
                       64'(got.frame_flags));
         compare_field("out_frame_length", 64'(res.status.frame_length),
                       64'(got.frame_length));
         compare_field("out_frame_data", res.status.frame_data, got.frame_data);
         compare_field("out_insertion_time", 64'(res.status.insertion_time),
                       64'(got.insertion_time));
         compare_field("occupancy", 64'(res.status.occupancy), 64'(got.occupancy));
         compare_field("is_full", 64'(res.status.is_full), 64'(got.is_full));
         compare_field("high_water", 64'(res.status.high_water), 64'(got.high_water));
         compare_field("put_count", 64'(res.status.put_count), 64'(got.put_count));
         compare_field("get_count", 64'(res.status.get_count), 64'(got.get_count));
         compare_field("overflow_count", 64'(res.status.overflow_count),
                       64'(got.overflow_count));
      endfunction

      function int unsigned outstanding();
         return expected_status.size();
      endfunction
   endclass

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_wdata  = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [CMD_W-1:0] req_tuser  = CMD_PUT;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic             rsp_tuser;
   logic [RSP_W-1:0] rsp_tdata;

   frame_ring_scoreboard sb;
   bit                   steady = 1'b0;
   int unsigned          cycle_count = 0;

   overwriting_frame_ring_buffer u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 28);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.apply_capacity(csr_wdata);
         if (req_tvalid && req_tready) begin
            sb.note_command(req_tuser, frame_request_type'(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_status(rsp_tuser, frame_status_type'(rsp_tdata));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic issue(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                        input logic [FLG_W-1:0] flags, input logic [LEN_W-1:0] len,
                        input logic [DAT_W-1:0] data, input logic [TIM_W-1:0] stamp);
      frame_request_type req;
      req = '{pad: '0, now_micros: stamp, frame_data: data, frame_length: len,
              frame_flags: flags, frame_id: id};
      if (!steady && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 28) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= req;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic issue_random_command(input bit fill_mode);
      int unsigned       pick;
      logic [CMD_W-1:0]  cmd;
      logic [ID_W-1:0]   id;
      logic [LEN_W-1:0]  len;
      pick = $urandom_range(99);
      if (pick < 3) begin
         cmd = CMD_CLEAR;
      end else if (fill_mode) begin
         cmd = (pick < 68) ? CMD_PUT : (pick < 88) ? CMD_GET : CMD_PEEK;
      end else begin
         cmd = (pick < 28) ? CMD_PUT : (pick < 83) ? CMD_GET : CMD_PEEK;
      end
      case ($urandom_range(19))
         0:       id = '0;
         1:       id = '1;
         default: id = ID_W'($urandom);
      endcase
      len = ($urandom_range(9) < 8) ? LEN_W'($urandom_range(8)) : LEN_W'($urandom_range(15, 9));
      issue(cmd, id, FLG_W'($urandom), len, {$urandom, $urandom}, $urandom);
   endtask

   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input int unsigned value);
      wait_until_idle();
      csr_valid <= 1'b1;
      csr_wdata <= CSR_W'(value & 'h3f);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned caps [10];
      int unsigned run_left;
      bit          fill_mode;
      sb = new();
      caps = '{63, 3, 1, 32, 17, 2, 0, 0, 0, 45};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty buffer, extremes, ordering at reset capacity
      issue(CMD_GET, '0, '0, '0, '0, '0);
      issue(CMD_PEEK, '1, '1, '1, '1, '1);
      issue(CMD_CLEAR, '0, '0, '0, '0, '0);
      issue(CMD_PUT, '1, '1, '1, '1, '1);
      issue(CMD_PUT, '0, '0, '0, '0, '0);
      issue(CMD_PUT, 29'h0abc_1234, 2'b01, 4'd8, 64'h0807_0605_0403_0201, 32'h8000_0000);
      issue(CMD_PEEK, '0, '0, '0, '0, '0);
      issue(CMD_GET, '0, '0, '0, '0, '0);
      issue(CMD_GET, '0, '0, '0, '0, '0);
      issue(CMD_PEEK, '0, '0, '0, '0, '0);
      issue(CMD_GET, '0, '0, '0, '0, '0);
      issue(CMD_GET, '0, '0, '0, '0, '0);

      // zero capacity acts as one slot: overwrite on every put when full
      write_capacity(0);
      issue(CMD_PUT, 29'h1555_5555, 2'b10, 4'd3, 64'haaaa_5555_aaaa_5555, 32'h1);
      issue(CMD_PUT, 29'h0aaa_aaaa, 2'b01, 4'd7, 64'h5555_aaaa_5555_aaaa, 32'h2);
      issue(CMD_PEEK, '0, '0, '0, '0, '0);
      issue(CMD_GET, '0, '0, '0, '0, '0);
      issue(CMD_GET, '0, '0, '0, '0, '0);
      issue(CMD_PUT, 29'h1, 2'b11, 4'd0, 64'h1, 32'hffff_fffe);
      issue(CMD_CLEAR, '0, '0, '0, '0, '0);
      issue(CMD_PEEK, '0, '0, '0, '0, '0);

      write_capacity(2);
      issue(CMD_PUT, 29'h11, 2'b00, 4'd1, 64'h11, 32'h11);
      issue(CMD_PUT, 29'h22, 2'b01, 4'd2, 64'h22, 32'h22);
      issue(CMD_PUT, 29'h33, 2'b10, 4'd15, 64'h33, 32'h33);
      issue(CMD_GET, '0, '0, '0, '0, '0);
      issue(CMD_GET, '0, '0, '0, '0, '0);

      for (int p = 0; p < 10; p++) begin
         if (caps[p] == 0) caps[p] = $urandom_range(63, 1);
         write_capacity(caps[p]);
         steady    = (p == 3);
         fill_mode = 1'b1;
         run_left  = $urandom_range(80, 20);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (run_left == 0) begin
               fill_mode = !fill_mode;
               run_left  = $urandom_range(80, 20);
            end
            run_left--;
            issue_random_command(fill_mode);
            if ($urandom_range(99) == 0) wait_until_idle();
         end
      end
      steady = 1'b0;

      wait_until_idle();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
